// ===== design/aeqc_pkg.sv =====
package aeqc_pkg;

    localparam int DATA_W              = 32;
    localparam int QUAT_FRAC_BITS_DEF  = 30;
    localparam int MRP_FRAC_BITS_DEF   = 27;

    // normalized magnitude width and the square-root datapath that follows from it
    localparam int NORM_BITS = 30;
    localparam int ROOT_W    = NORM_BITS + 1;
    localparam int SQR_W     = 2 * NORM_BITS + 2;

    localparam int PROD_W  = 2 * DATA_W;
    localparam int SUM_W   = PROD_W + 2;
    localparam int MAG_W   = PROD_W;
    localparam int BL_W    = 7;
    localparam int CHUNK_W = 16;
    localparam int N_CHUNK = MAG_W / CHUNK_W;
    localparam int CBL_W   = 5;

    typedef logic signed [DATA_W-1:0] t_word;
    typedef logic [3:0][DATA_W-1:0]   t_quat;

    function automatic logic [DATA_W-1:0] abs_word(input t_word v);
        abs_word = v[DATA_W-1] ? (~v + 1'b1) : v;
    endfunction

endpackage

// ===== design/aeqc_div_pipe.sv =====
module aeqc_div_pipe
    import aeqc_pkg::*;
#(
    parameter int LANES = 4,
    parameter int DW    = 64,
    parameter int QB    = 31,
    parameter int SW    = 1
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  logic [SW-1:0]                i_side,
    input  logic [DW-1:0]                i_den,
    input  logic [LANES-1:0][DW-1:0]     i_hi,
    input  logic [LANES-1:0][QB-1:0]     i_lo,
    output logic                         o_valid,
    output logic [SW-1:0]                o_side,
    output logic [LANES-1:0][QB-1:0]     o_quo
);

    // one restoring step per stage; the low numerator bits shift out as quotient bits shift in
    logic                         r_v    [QB];
    logic [SW-1:0]                r_side [QB];
    logic [DW-1:0]                r_den  [QB];
    logic [LANES-1:0][DW-1:0]     r_rem  [QB];
    logic [LANES-1:0][QB-1:0]     r_x    [QB];

    for (genvar k = 0; k < QB; k++) begin : g_step
        logic                     c_v;
        logic [SW-1:0]            c_side;
        logic [DW-1:0]            c_den;
        logic [LANES-1:0][DW-1:0] c_rem;
        logic [LANES-1:0][QB-1:0] c_x;
        logic [LANES-1:0][DW-1:0] n_rem;
        logic [LANES-1:0][QB-1:0] n_x;

        if (k == 0) begin : g_first
            assign c_v    = i_valid;
            assign c_side = i_side;
            assign c_den  = i_den;
            assign c_rem  = i_hi;
            assign c_x    = i_lo;
        end else begin : g_next
            assign c_v    = r_v[k-1];
            assign c_side = r_side[k-1];
            assign c_den  = r_den[k-1];
            assign c_rem  = r_rem[k-1];
            assign c_x    = r_x[k-1];
        end

        always_comb begin
            logic [DW:0] t;
            for (int l = 0; l < LANES; l++) begin
                t = {c_rem[l], c_x[l][QB-1]};
                if (t >= {1'b0, c_den}) begin
                    n_rem[l] = DW'(t - {1'b0, c_den});
                    n_x[l]   = {c_x[l][QB-2:0], 1'b1};
                end else begin
                    n_rem[l] = t[DW-1:0];
                    n_x[l]   = {c_x[l][QB-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= c_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side[k] <= c_side;
                r_den[k]  <= c_den;
                r_rem[k]  <= n_rem;
                r_x[k]    <= n_x;
            end
        end
    end

    assign o_valid = r_v[QB-1];
    assign o_side  = r_side[QB-1];
    assign o_quo   = r_x[QB-1];

endmodule

// ===== design/aeqc_isqrt.sv =====
module aeqc_isqrt
    import aeqc_pkg::*;
#(
    parameter int SW = 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic [SW-1:0]      i_side,
    input  logic [SQR_W-1:0]   i_val,
    output logic               o_valid,
    output logic [SW-1:0]      o_side,
    output logic [ROOT_W-1:0]  o_root
);

    localparam int NSTEP = ROOT_W;
    localparam int RM_W  = ROOT_W + 2;

    // two radicand bits per stage, one root bit out
    logic               r_v    [NSTEP];
    logic [SW-1:0]      r_side [NSTEP];
    logic [SQR_W-1:0]   r_x    [NSTEP];
    logic [RM_W-1:0]    r_rem  [NSTEP];
    logic [ROOT_W-1:0]  r_root [NSTEP];

    for (genvar k = 0; k < NSTEP; k++) begin : g_step
        logic              c_v;
        logic [SW-1:0]     c_side;
        logic [SQR_W-1:0]  c_x;
        logic [RM_W-1:0]   c_rem;
        logic [ROOT_W-1:0] c_root;
        logic [RM_W-1:0]   n_rem;
        logic [ROOT_W-1:0] n_root;

        if (k == 0) begin : g_first
            assign c_v    = i_valid;
            assign c_side = i_side;
            assign c_x    = i_val;
            assign c_rem  = '0;
            assign c_root = '0;
        end else begin : g_next
            assign c_v    = r_v[k-1];
            assign c_side = r_side[k-1];
            assign c_x    = r_x[k-1];
            assign c_rem  = r_rem[k-1];
            assign c_root = r_root[k-1];
        end

        always_comb begin
            logic [RM_W+1:0] t;
            logic [RM_W+1:0] trial;
            t     = {c_rem, c_x[SQR_W-1:SQR_W-2]};
            trial = {2'b00, c_root, 2'b01};
            if (t >= trial) begin
                n_rem  = RM_W'(t - trial);
                n_root = {c_root[ROOT_W-2:0], 1'b1};
            end else begin
                n_rem  = t[RM_W-1:0];
                n_root = {c_root[ROOT_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= c_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side[k] <= c_side;
                r_x[k]    <= {c_x[SQR_W-3:0], 2'b00};
                r_rem[k]  <= n_rem;
                r_root[k] <= n_root;
            end
        end
    end

    assign o_valid = r_v[NSTEP-1];
    assign o_side  = r_side[NSTEP-1];
    assign o_root  = r_root[NSTEP-1];

endmodule

// ===== design/attitude_error_quaternion_compose.sv =====
// Attitude error composition: scaled modified Rodrigues error vector plus a
// reference quaternion in, composed and renormalized unit quaternion out.
//
// Slave channel (s_axis_*): one transaction per item, tdata carries the three
// error components (Q5.27 by default) and the reference quaternion x, y, z, w
// (Q2.30). Master channel (m_axis_*): one transaction per item, tdata carries
// the result quaternion x, y, z, w (Q2.30), tuser the sign-flip and
// degenerate flags.
//
// The pipeline is made of two pipelined dividers of QUAT_FRAC_BITS+1 stages
// each, a 31-stage square root, and 16 stages of multiply, sum, max and
// normalize logic. Throughput is one transaction per cycle while m_axis_tready
// does not hold the pipeline; every stage holds one item.
//
// The pipeline advances as a whole whenever the output register is empty or
// being taken. When the receiver holds m_axis_tready low with a result
// waiting, every stage holds and s_axis_tready drops; nothing is lost or
// repeated. Synchronous reset clears all valid bits; no data is flushed.
module attitude_error_quaternion_compose
    import aeqc_pkg::*;
#(
    parameter int QUAT_FRAC_BITS = QUAT_FRAC_BITS_DEF,
    parameter int MRP_FRAC_BITS  = MRP_FRAC_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // mrp_x, mrp_y, mrp_z, ref_x, ref_y, ref_z, ref_w
    input  logic [223:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // q_x, q_y, q_z, q_w
    output logic [127:0] m_axis_tdata,
    // sign_flipped, degenerate
    output logic [1:0]   m_axis_tuser
);

    localparam int QB = QUAT_FRAC_BITS + 1;
    localparam logic [MAG_W-1:0] C16 = MAG_W'(64'd16 << (2 * MRP_FRAC_BITS));
    localparam int RW = 4 * DATA_W;
    localparam int FD_SW = 4 + RW;
    localparam int SQ_SW = 4 * NORM_BITS + 4 + RW + 1;
    localparam int QD_SW = 4 + RW + 1;

    logic en;
    logic r_out_v;

    // advance everything when the output slot is free or being emptied
    assign en            = !r_out_v || m_axis_tready;
    assign s_axis_tready = en;

    t_word in_mrp [3];
    t_quat in_ref;
    always_comb begin
        for (int i = 0; i < 3; i++) in_mrp[i] = t_word'(s_axis_tdata[i*DATA_W +: DATA_W]);
        for (int i = 0; i < 4; i++) in_ref[i] = s_axis_tdata[(3+i)*DATA_W +: DATA_W];
    end

    // ---- stage A: magnitudes of the error vector
    logic              r_a_v;
    logic [DATA_W-1:0] r_a_am [3];
    logic [2:0]        r_a_an;
    t_quat             r_a_r;

    // ---- stage B: squares
    logic              r_b_v;
    logic [MAG_W-1:0]  r_b_sq [3];
    logic [DATA_W-1:0] r_b_am [3];
    logic [2:0]        r_b_an;
    t_quat             r_b_r;

    // ---- stage C: denominator 16+|a|^2 and numerators
    logic              r_c_v;
    logic [MAG_W-1:0]  r_c_den;
    logic [3:0][MAG_W-1:0] r_c_num;
    logic [FD_SW-1:0]  r_c_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
        end else if (en) begin
            r_a_v <= s_axis_tvalid;
            r_b_v <= r_a_v;
            r_c_v <= r_b_v;
        end
    end

    logic [MAG_W-1:0] b_sum;
    assign b_sum = r_b_sq[0] + r_b_sq[1] + r_b_sq[2];

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_a_am[i] <= abs_word(in_mrp[i]);
                r_a_an[i] <= in_mrp[i][DATA_W-1];
                r_b_sq[i] <= MAG_W'(r_a_am[i]) * MAG_W'(r_a_am[i]);
                r_b_am[i] <= r_a_am[i];
                r_c_num[i] <= MAG_W'(r_b_am[i]) << (3 + MRP_FRAC_BITS);
            end
            r_a_r  <= in_ref;
            r_b_an <= r_a_an;
            r_b_r  <= r_a_r;
            r_c_den    <= C16 + b_sum;
            r_c_num[3] <= (b_sum <= C16) ? (C16 - b_sum) : (b_sum - C16);
            // signs of e: x, y, z from the error vector, w from the 16 - |a|^2 comparison
            r_c_side   <= {(b_sum > C16), r_b_an, r_b_r};
        end
    end

    // ---- error quaternion divider: floor(num * 2^Q / den)
    logic [3:0][MAG_W-1:0] fd_hi;
    logic [3:0][QB-1:0]    fd_lo;
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            fd_hi[i] = r_c_num[i] >> 1;
            fd_lo[i] = {r_c_num[i][0], {QUAT_FRAC_BITS{1'b0}}};
        end
    end

    logic                fd_v;
    logic [FD_SW-1:0]    fd_side;
    logic [3:0][QB-1:0]  fd_quo;

    aeqc_div_pipe #(
        .LANES (4),
        .DW    (MAG_W),
        .QB    (QB),
        .SW    (FD_SW)
    ) u_err_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_c_v),
        .i_side  (r_c_side),
        .i_den   (r_c_den),
        .i_hi    (fd_hi),
        .i_lo    (fd_lo),
        .o_valid (fd_v),
        .o_side  (fd_side),
        .o_quo   (fd_quo)
    );

    logic [3:0] fd_neg;
    t_quat      fd_r;
    assign fd_neg = fd_side[FD_SW-1 -: 4];
    assign fd_r   = fd_side[RW-1:0];

    // ---- stage D: signed error quaternion e
    logic  r_d_v;
    t_word r_d_e [4];
    t_quat r_d_r;

    // ---- stage E: 16 partial products e_i * r_j
    logic                     r_e_v;
    logic signed [PROD_W-1:0] r_e_pr [4][4];
    t_quat                    r_e_r;

    // ---- stage F: product quaternion P
    logic                    r_f_v;
    logic signed [SUM_W-1:0] r_f_p [4];
    t_quat                   r_f_r;

    // ---- stage G: magnitudes of P
    logic             r_g_v;
    logic [MAG_W-1:0] r_g_m [4];
    logic [3:0]       r_g_n;
    t_quat            r_g_r;

    // ---- stage H: largest magnitude
    logic             r_h_v;
    logic [MAG_W-1:0] r_h_big;
    logic [MAG_W-1:0] r_h_m [4];
    logic [3:0]       r_h_n;
    t_quat            r_h_r;

    // ---- stage I: per-chunk leading-one search
    logic             r_i_v;
    logic [N_CHUNK-1:0] r_i_nz;
    logic [CBL_W-1:0] r_i_cbl [N_CHUNK];
    logic [MAG_W-1:0] r_i_m [4];
    logic [3:0]       r_i_n;
    t_quat            r_i_r;

    // ---- stage J: bit length of the largest magnitude
    logic             r_j_v;
    logic [BL_W-1:0]  r_j_bl;
    logic             r_j_deg;
    logic [MAG_W-1:0] r_j_m [4];
    logic [3:0]       r_j_n;
    t_quat            r_j_r;

    // ---- stage K: common shift to NORM_BITS significant bits
    logic                 r_k_v;
    logic [NORM_BITS-1:0] r_k_p [4];
    logic                 r_k_deg;
    logic [3:0]           r_k_n;
    t_quat                r_k_r;

    // ---- stage L: squares of the normalized magnitudes
    logic                   r_l_v;
    logic [2*NORM_BITS-1:0] r_l_sq [4];
    logic [NORM_BITS-1:0]   r_l_p [4];
    logic                   r_l_deg;
    logic [3:0]             r_l_n;
    t_quat                  r_l_r;

    // ---- stage M: sum of squares
    logic             r_m_v;
    logic [SQR_W-1:0] r_m_n2;
    logic [SQ_SW-1:0] r_m_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_v <= 1'b0;
            r_e_v <= 1'b0;
            r_f_v <= 1'b0;
            r_g_v <= 1'b0;
            r_h_v <= 1'b0;
            r_i_v <= 1'b0;
            r_j_v <= 1'b0;
            r_k_v <= 1'b0;
            r_l_v <= 1'b0;
            r_m_v <= 1'b0;
        end else if (en) begin
            r_d_v <= fd_v;
            r_e_v <= r_d_v;
            r_f_v <= r_e_v;
            r_g_v <= r_f_v;
            r_h_v <= r_g_v;
            r_i_v <= r_h_v;
            r_j_v <= r_i_v;
            r_k_v <= r_j_v;
            r_l_v <= r_k_v;
            r_m_v <= r_l_v;
        end
    end

    logic [MAG_W-1:0] h_max01, h_max23;
    assign h_max01 = (r_g_m[0] > r_g_m[1]) ? r_g_m[0] : r_g_m[1];
    assign h_max23 = (r_g_m[2] > r_g_m[3]) ? r_g_m[2] : r_g_m[3];

    logic [N_CHUNK-1:0] i_nz;
    logic [CBL_W-1:0]   i_cbl [N_CHUNK];
    always_comb begin
        for (int c = 0; c < N_CHUNK; c++) begin
            i_nz[c]  = |r_h_big[c*CHUNK_W +: CHUNK_W];
            i_cbl[c] = '0;
            for (int j = 0; j < CHUNK_W; j++) begin
                if (r_h_big[c*CHUNK_W + j]) i_cbl[c] = CBL_W'(j + 1);
            end
        end
    end

    logic [BL_W-1:0] j_bl;
    always_comb begin
        j_bl = '0;
        for (int c = 0; c < N_CHUNK; c++) begin
            if (r_i_nz[c]) j_bl = BL_W'(c * CHUNK_W) + BL_W'(r_i_cbl[c]);
        end
    end

    logic [NORM_BITS-1:0] k_p [4];
    always_comb begin
        logic [MAG_W-1:0] t;
        for (int i = 0; i < 4; i++) begin
            if (r_j_bl > BL_W'(NORM_BITS)) begin
                t = r_j_m[i] >> (r_j_bl - BL_W'(NORM_BITS));
            end else begin
                t = r_j_m[i] << (BL_W'(NORM_BITS) - r_j_bl);
            end
            k_p[i] = t[NORM_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 4; i++) begin
                r_d_e[i] <= fd_neg[i] ? -t_word'(fd_quo[i]) : t_word'(fd_quo[i]);
                for (int j = 0; j < 4; j++) begin
                    r_e_pr[i][j] <= r_d_e[i] * t_word'(r_d_r[j]);
                end
                r_g_m[i] <= r_f_p[i][SUM_W-1] ? MAG_W'(-r_f_p[i]) : MAG_W'(r_f_p[i]);
                r_g_n[i] <= r_f_p[i][SUM_W-1];
                r_h_m[i] <= r_g_m[i];
                r_i_m[i] <= r_h_m[i];
                r_j_m[i] <= r_i_m[i];
                r_k_p[i] <= k_p[i];
                r_l_sq[i] <= (2*NORM_BITS)'(r_k_p[i]) * (2*NORM_BITS)'(r_k_p[i]);
                r_l_p[i]  <= r_k_p[i];
            end
            r_d_r <= fd_r;

            r_e_r <= r_d_r;

            r_f_p[0] <=  r_e_pr[3][0] + r_e_pr[2][1] - r_e_pr[1][2] + r_e_pr[0][3];
            r_f_p[1] <= -r_e_pr[2][0] + r_e_pr[3][1] + r_e_pr[0][2] + r_e_pr[1][3];
            r_f_p[2] <=  r_e_pr[1][0] - r_e_pr[0][1] + r_e_pr[3][2] + r_e_pr[2][3];
            r_f_p[3] <= -r_e_pr[0][0] - r_e_pr[1][1] - r_e_pr[2][2] + r_e_pr[3][3];
            r_f_r    <= r_e_r;

            r_g_r   <= r_f_r;

            r_h_big <= (h_max01 > h_max23) ? h_max01 : h_max23;
            r_h_n   <= r_g_n;
            r_h_r   <= r_g_r;

            r_i_nz  <= i_nz;
            r_i_cbl <= i_cbl;
            r_i_n   <= r_h_n;
            r_i_r   <= r_h_r;

            r_j_bl  <= j_bl;
            r_j_deg <= ~|r_i_nz;
            r_j_n   <= r_i_n;
            r_j_r   <= r_i_r;

            r_k_deg <= r_j_deg;
            r_k_n   <= r_j_n;
            r_k_r   <= r_j_r;

            r_l_deg <= r_k_deg;
            r_l_n   <= r_k_n;
            r_l_r   <= r_k_r;

            r_m_n2   <= SQR_W'(r_l_sq[0]) + SQR_W'(r_l_sq[1])
                      + SQR_W'(r_l_sq[2]) + SQR_W'(r_l_sq[3]);
            r_m_side <= {r_l_p[3], r_l_p[2], r_l_p[1], r_l_p[0], r_l_n, r_l_deg, r_l_r};
        end
    end

    // ---- square root of the sum of squares
    logic              sq_v;
    logic [SQ_SW-1:0]  sq_side;
    logic [ROOT_W-1:0] sq_root;

    aeqc_isqrt #(
        .SW (SQ_SW)
    ) u_norm_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_m_v),
        .i_side  (r_m_side),
        .i_val   (r_m_n2),
        .o_valid (sq_v),
        .o_side  (sq_side),
        .o_root  (sq_root)
    );

    // ---- rounded quotient (p * 2^Q + floor(n/2)) / n
    logic [3:0][DATA_W-1:0] qd_hi;
    logic [3:0][QB-1:0]     qd_lo;
    always_comb begin
        logic [MAG_W-1:0] num;
        for (int i = 0; i < 4; i++) begin
            num = (MAG_W'(sq_side[SQ_SW-1-(3-i)*NORM_BITS -: NORM_BITS]) << QUAT_FRAC_BITS)
                + MAG_W'(sq_root >> 1);
            qd_hi[i] = DATA_W'(num >> QB);
            qd_lo[i] = num[QB-1:0];
        end
    end

    logic               qd_v;
    logic [QD_SW-1:0]   qd_side;
    logic [3:0][QB-1:0] qd_quo;

    aeqc_div_pipe #(
        .LANES (4),
        .DW    (DATA_W),
        .QB    (QB),
        .SW    (QD_SW)
    ) u_norm_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (sq_v),
        .i_side  (sq_side[QD_SW-1:0]),
        .i_den   (DATA_W'(sq_root)),
        .i_hi    (qd_hi),
        .i_lo    (qd_lo),
        .o_valid (qd_v),
        .o_side  (qd_side),
        .o_quo   (qd_quo)
    );

    logic [3:0] qd_neg;
    logic       qd_deg;
    t_quat      qd_r;
    assign qd_neg = qd_side[QD_SW-1 -: 4];
    assign qd_deg = qd_side[RW];
    assign qd_r   = qd_side[RW-1:0];

    // ---- stage N: signed output candidate
    logic  r_n_v;
    t_word r_n_q [4];
    logic  r_n_deg;
    t_quat r_n_r;

    // ---- stage O: dot-product terms with the reference
    logic                     r_o_v;
    logic signed [PROD_W-1:0] r_o_qr [4];
    t_word                    r_o_q [4];
    logic                     r_o_deg;

    // ---- output register
    t_word r_out_q [4];
    logic  r_out_flip;
    logic  r_out_deg;

    logic signed [SUM_W-1:0] o_dot;
    assign o_dot = r_o_qr[0] + r_o_qr[1] + r_o_qr[2] + r_o_qr[3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n_v   <= 1'b0;
            r_o_v   <= 1'b0;
            r_out_v <= 1'b0;
        end else if (en) begin
            r_n_v   <= qd_v;
            r_o_v   <= r_n_v;
            r_out_v <= r_o_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 4; i++) begin
                r_n_q[i]  <= qd_neg[i] ? -t_word'(qd_quo[i]) : t_word'(qd_quo[i]);
                r_o_qr[i] <= r_n_q[i] * t_word'(r_n_r[i]);
                r_o_q[i]  <= r_n_q[i];
                // zero product: zero quaternion; otherwise keep near the reference
                if (r_o_deg) begin
                    r_out_q[i] <= '0;
                end else if (o_dot[SUM_W-1]) begin
                    r_out_q[i] <= -r_o_q[i];
                end else begin
                    r_out_q[i] <= r_o_q[i];
                end
            end
            r_n_deg    <= qd_deg;
            r_n_r      <= qd_r;
            r_o_deg    <= r_n_deg;
            r_out_flip <= !r_o_deg && o_dot[SUM_W-1];
            r_out_deg  <= r_o_deg;
        end
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = {r_out_q[3], r_out_q[2], r_out_q[1], r_out_q[0]};
    assign m_axis_tuser  = {r_out_deg, r_out_flip};

endmodule
